>>> hw/rtl/u8d_pkg.sv
// u8d_pkg: shared types and constants for the strict UTF-8 decoder.
// Holds the decoder state and result structs used by u8d_step and the top level.
// No dependencies.
package u8d_pkg;

	localparam int OFFSET_WIDTH = 31;
	localparam int AFTER_WIDTH  = 31;
	localparam int CP_WIDTH     = 21;
	localparam int BYTE_WIDTH   = 8;

	typedef logic [OFFSET_WIDTH-1:0] offset_t;
	typedef logic [AFTER_WIDTH-1:0]  after_t;
	typedef logic [CP_WIDTH-1:0]     cp_t;
	typedef logic [BYTE_WIDTH-1:0]   byte_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam byte_t LEAD1_MAX = 8'h7f;
	localparam byte_t LEAD2_MIN = 8'hc2;
	localparam byte_t LEAD2_MAX = 8'hdf;
	localparam byte_t LEAD3_MIN = 8'he0;
	localparam byte_t LEAD3_MAX = 8'hef;
	localparam byte_t LEAD4_MIN = 8'hf0;
	localparam byte_t LEAD4_MAX = 8'hf4;
	localparam byte_t CONT_MASK = 8'hc0;
	localparam byte_t CONT_TAG  = 8'h80;

	localparam cp_t MIN_LEN2 = 21'h80;
	localparam cp_t MIN_LEN3 = 21'h800;
	localparam cp_t MIN_LEN4 = 21'h10000;
	localparam cp_t CP_MAX   = 21'h10ffff;
	localparam cp_t SURR_LO  = 21'hd800;
	localparam cp_t SURR_HI  = 21'hdfff;
	localparam cp_t BMP_MAX  = 21'hffff;

	localparam logic [1:0] SEQ_ONE   = 2'd0;
	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

	typedef struct packed {
		logic [1:0] pending;
		logic [1:0] seq_len;
		cp_t        acc;
		offset_t    seq_begin;
		offset_t    byte_pos;
		offset_t    u16_pos;
		logic       failed;
	} dec_state_t;

	typedef struct packed {
		logic    status;
		cp_t     code_point;
		offset_t byte_start;
		offset_t byte_stop;
		offset_t utf16_start;
		offset_t utf16_stop;
		offset_t bad_offset;
		logic    string_done;
	} dec_result_t;

endpackage

>>> hw/rtl/u8d_step.sv
// u8d_step: per-byte decode logic; next decoder state and optional result.
// Purely combinational; the caller holds the state register.
// Depends on u8d_pkg.
module u8d_step (
	input  u8d_pkg::dec_state_t  cur,
	input  u8d_pkg::byte_t       data_byte,
	input  u8d_pkg::after_t      bytes_after,
	output u8d_pkg::dec_state_t  nxt,
	output u8d_pkg::dec_result_t res,
	output logic                 res_valid
);
	import u8d_pkg::*;

	always_comb begin
		logic       last;
		offset_t    pos;
		offset_t    next_pos;
		logic [1:0] n;
		cp_t        v;
		cp_t        acc_new;
		logic [1:0] pend_new;
		logic       lead_ok;
		logic       err;
		offset_t    err_at;
		logic       pt;
		cp_t        pt_cp;
		offset_t    pt_start;
		logic       bad_range;

		last     = (bytes_after == '0);
		pos      = cur.byte_pos;
		next_pos = pos + offset_t'(1);
		n        = SEQ_ONE;
		v        = '0;
		lead_ok  = 1'b1;
		err      = 1'b0;
		err_at   = pos;
		pt       = 1'b0;
		pt_cp    = '0;
		pt_start = pos;
		acc_new  = {cur.acc[CP_WIDTH-7:0], data_byte[5:0]};
		pend_new = cur.pending - 2'd1;
		bad_range = 1'b0;

		nxt          = cur;
		nxt.byte_pos = next_pos;
		res          = '0;
		res_valid    = 1'b0;

		if (!cur.failed) begin
			if (cur.pending == 2'd0) begin
				if (data_byte <= LEAD1_MAX) begin
					v = cp_t'(data_byte);
					n = SEQ_ONE;
				end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
					v = cp_t'(data_byte[4:0]);
					n = SEQ_TWO;
				end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
					v = cp_t'(data_byte[3:0]);
					n = SEQ_THREE;
				end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
					v = cp_t'(data_byte[2:0]);
					n = SEQ_FOUR;
				end else begin
					lead_ok = 1'b0;
				end

				if (!lead_ok || bytes_after < after_t'(n)) begin
					err    = 1'b1;
					err_at = pos;
				end else if (n == SEQ_ONE) begin
					pt       = 1'b1;
					pt_cp    = v;
					pt_start = pos;
				end else begin
					nxt.acc       = v;
					nxt.pending   = n;
					nxt.seq_len   = n;
					nxt.seq_begin = pos;
				end
			end else begin
				if ((data_byte & CONT_MASK) != CONT_TAG) begin
					err    = 1'b1;
					err_at = pos;
				end else begin
					nxt.acc     = acc_new;
					nxt.pending = pend_new;
					if (pend_new != 2'd0) begin
						if (last) begin
							err    = 1'b1;
							err_at = cur.seq_begin;
						end
					end else begin
						bad_range = (cur.seq_len == SEQ_TWO   && acc_new < MIN_LEN2) ||
						            (cur.seq_len == SEQ_THREE && acc_new < MIN_LEN3) ||
						            (cur.seq_len == SEQ_FOUR  && acc_new < MIN_LEN4) ||
						            acc_new > CP_MAX ||
						            (acc_new >= SURR_LO && acc_new <= SURR_HI);
						if (bad_range) begin
							err    = 1'b1;
							err_at = cur.seq_begin;
						end else begin
							pt          = 1'b1;
							pt_cp       = acc_new;
							pt_start    = cur.seq_begin;
							nxt.seq_len = 2'd0;
							nxt.acc     = '0;
						end
					end
				end
			end
		end

		if (err) begin
			res_valid       = 1'b1;
			res.status      = STATUS_BAD;
			res.bad_offset  = err_at;
			res.string_done = 1'b1;
			nxt.failed      = 1'b1;
			nxt.pending     = 2'd0;
			nxt.seq_len     = 2'd0;
			nxt.acc         = '0;
		end else if (pt) begin
			res_valid       = 1'b1;
			res.status      = STATUS_OK;
			res.code_point  = pt_cp;
			res.byte_start  = pt_start;
			res.byte_stop   = next_pos;
			res.utf16_start = cur.u16_pos;
			res.utf16_stop  = cur.u16_pos + ((pt_cp > BMP_MAX) ? offset_t'(2) : offset_t'(1));
			res.string_done = last;
			nxt.u16_pos     = res.utf16_stop;
		end

		if (last) begin
			nxt = '0;
		end
	end

endmodule

>>> hw/rtl/utf8_validating_decoder_core.sv
// utf8_validating_decoder_core: streaming strict UTF-8 decoder, one byte per transfer.
// Input register, u8d_step decode logic with the string state, result register.
// Depends on u8d_pkg and u8d_step.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_ready | data_byte, bytes_after
//   out     | out_valid/out_ready | status, code_point, byte_start, byte_stop,
//           |                     | utf16_start, utf16_stop, bad_offset, string_done
//
// Throughput is one byte per cycle unless the output stalls: the string state updates
// through u8d_step. A byte passes the input register, then its result the result register.
// Bytes that yield no result (continuations, bytes after an error) only update state.
// Reset clears all string state; after the final byte of a string it clears as well.
// A stalled output holds the input register; in_ready drops only then.
module utf8_validating_decoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  u8d_pkg::byte_t       data_byte,
	input  u8d_pkg::after_t      bytes_after,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output u8d_pkg::cp_t         code_point,
	output u8d_pkg::offset_t     byte_start,
	output u8d_pkg::offset_t     byte_stop,
	output u8d_pkg::offset_t     utf16_start,
	output u8d_pkg::offset_t     utf16_stop,
	output u8d_pkg::offset_t     bad_offset,
	output logic                 string_done
);
	import u8d_pkg::*;

	logic        valid_s1;
	byte_t       byte_s1;
	after_t      after_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res_nxt;
	logic        res_nxt_valid;
	logic        out_valid_q;
	dec_result_t result_q;
	logic        advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	u8d_step u_step (
		.cur         (state_q),
		.data_byte   (byte_s1),
		.bytes_after (after_s1),
		.nxt         (state_nxt),
		.res         (res_nxt),
		.res_valid   (res_nxt_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && res_nxt_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			after_s1 <= bytes_after;
		end
		if (advance && valid_s1 && res_nxt_valid) begin
			result_q <= res_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = result_q.status;
	assign code_point  = result_q.code_point;
	assign byte_start  = result_q.byte_start;
	assign byte_stop   = result_q.byte_stop;
	assign utf16_start = result_q.utf16_start;
	assign utf16_stop  = result_q.utf16_stop;
	assign bad_offset  = result_q.bad_offset;
	assign string_done = result_q.string_done;

	a_pending_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending <= state_q.seq_len)
		else $error("pending count exceeds sequence length");

	a_failed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.failed |-> (state_q.pending == 2'd0 && state_q.acc == '0))
		else $error("sequence state left over after error");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.status == STATUS_BAD) |->
			(result_q.string_done && result_q.code_point == '0))
		else $error("error result malformed");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with free output");

endmodule
